### rtl/alloc_index_dup_checker_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the allocation index duplicate checker
// Both macros expect signals clk and arst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ALLOC_INDEX_DUP_CHECKER_TOP_ASSERT_SVH
`define ALLOC_INDEX_DUP_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define AIDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AIDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/aidc_pkg.sv
// ---------------------------------------------------------------------------
// aidc_pkg
// Types and constants shared by the allocation index duplicate checker.
// ---------------------------------------------------------------------------
package aidc_pkg;

	localparam int ENTRY_W  = 32;
	localparam int BCNT_W   = 13;
	localparam int POS_O_W  = 10;
	localparam int TOT_W    = 24;
	localparam int TOT_N    = 5;
	localparam int EPOCH_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
	localparam logic [TOT_W-1:0]   TOT_MAX     = {TOT_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE   = 2'd2;

	localparam logic [BCNT_W-1:0]  BLOCK_COUNT_RST = 13'd4096;
	localparam logic [ENTRY_W-1:0] FREE_CODE_RST   = 32'hFFFF_FFFF;
	localparam logic [ENTRY_W-1:0] LAST_CODE_RST   = 32'hFFFF_FFFE;

	// running total slots
	localparam int TOT_ALLOC = 0;
	localparam int TOT_LAST  = 1;
	localparam int TOT_FREE  = 2;
	localparam int TOT_CORR  = 3;
	localparam int TOT_DUPV  = 4;

	typedef enum logic [1:0] {
		CLS_ALLOC   = 2'd0,
		CLS_LAST    = 2'd1,
		CLS_FREE    = 2'd2,
		CLS_CORRUPT = 2'd3
	} cls_t;

	// one table entry; an epoch other than the current one reads as unseen
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [POS_O_W-1:0] first_pos;
		logic               dup;
	} tbl_ent_t;

	typedef struct packed {
		logic [POS_O_W-1:0] first_pos;
		logic               dup;
	} tbl_wdat_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic blk_adv;
	} tbl_ctl_t;

	typedef struct packed {
		logic clearing;
		logic last_epoch;
	} tbl_stat_t;

	typedef struct packed {
		logic               seen;
		logic               dup;
		logic [POS_O_W-1:0] first_pos;
	} tbl_hit_t;

endpackage

### rtl/aidc_seen_table.sv
// ---------------------------------------------------------------------------
// aidc_seen_table
// Per-value seen/duplicate table with epoch tags, write forwarding and a
// clearing sweep after reset and on epoch wrap.
// ---------------------------------------------------------------------------
`include "alloc_index_dup_checker_top_assert.svh"

module aidc_seen_table #(
	parameter int MAX_BLOCKS = 4096,
	localparam int AW = $clog2(MAX_BLOCKS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aidc_pkg::tbl_ctl_t   ctl,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  aidc_pkg::tbl_wdat_t  wr_dat,
	output aidc_pkg::tbl_hit_t   hit,
	output aidc_pkg::tbl_stat_t  stat
);

	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BLOCKS - 1);

	aidc_pkg::tbl_ent_t mem [MAX_BLOCKS];
	aidc_pkg::tbl_ent_t rd_q;
	aidc_pkg::tbl_ent_t fwd_q;
	aidc_pkg::tbl_ent_t eff;
	aidc_pkg::tbl_ent_t mem_wdat;

	logic [AW-1:0]                rd_addr_s1;
	logic [AW-1:0]                fwd_addr_q;
	logic                         fwd_v_q;
	logic                         clearing_q;
	logic [AW-1:0]                clr_cnt_q;
	logic [aidc_pkg::EPOCH_W-1:0] epoch_q;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdat  = '0;
		end else begin
			mem_we    = ctl.wr_en;
			mem_waddr = wr_addr;
			mem_wdat  = '{epoch: epoch_q, first_pos: wr_dat.first_pos, dup: wr_dat.dup};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdat;
		end
		if (ctl.rd_en) begin
			rd_q       <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
		if (!clearing_q && ctl.wr_en) begin
			fwd_q      <= mem_wdat;
			fwd_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			epoch_q    <= aidc_pkg::EPOCH_FIRST;
			fwd_v_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				fwd_v_q   <= 1'b0;
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == CLR_LAST) begin
					clearing_q <= 1'b0;
				end
			end else begin
				if (ctl.wr_en) begin
					fwd_v_q <= 1'b1;
				end
				if (ctl.blk_adv) begin
					if (epoch_q == aidc_pkg::EPOCH_MAX) begin
						// tags would alias: sweep the table back to unseen
						clearing_q <= 1'b1;
						clr_cnt_q  <= '0;
						epoch_q    <= aidc_pkg::EPOCH_FIRST;
					end else begin
						epoch_q <= epoch_q + aidc_pkg::EPOCH_W'(1);
					end
				end
			end
		end
	end

	// the read may have missed the write made at the same edge
	assign eff = (fwd_v_q && fwd_addr_q == rd_addr_s1) ? fwd_q : rd_q;

	assign hit.seen      = (eff.epoch == epoch_q);
	assign hit.dup       = (eff.epoch == epoch_q) && eff.dup;
	assign hit.first_pos = eff.first_pos;

	assign stat.clearing   = clearing_q;
	assign stat.last_epoch = (epoch_q == aidc_pkg::EPOCH_MAX);

	`AIDC_ASSERT_IMP(a_no_wr_in_clear, clearing_q, !ctl.wr_en, "item write during clear sweep")
	`AIDC_ASSERT_NXT(a_clear_ends, clearing_q && clr_cnt_q == CLR_LAST,
		!clearing_q && epoch_q == aidc_pkg::EPOCH_FIRST, "clear sweep did not end cleanly")
	`AIDC_ASSERT_IMP(a_epoch_live, 1'b1, epoch_q != '0, "epoch reserved for cleared entries")

endmodule

### rtl/alloc_index_dup_checker_top.sv
// ---------------------------------------------------------------------------
// alloc_index_dup_checker_top
// Classifies allocation index entries, flags duplicates per block and keeps
// saturating running totals.
// ---------------------------------------------------------------------------
// Takes one index entry per clock while in_stall is low and returns one
// result per entry through the stage 1 and output registers. The seen table
// lives in a single synchronous memory of MAX_BLOCKS entries that is read at
// acceptance and written back when the entry leaves stage 1; a forwarding
// register covers back-to-back hits on the same value. Table entries carry
// an 8-bit block epoch, so a block end needs no sweep. After reset, and once
// every 255 blocks when the epoch wraps, the table is swept back to unseen
// with in_stall high; in_stall also rises while a wrapping block end waits.
// Configuration writes go straight to registers and are allowed at any time
// the block is idle, including during the sweep.
// ---------------------------------------------------------------------------
`include "alloc_index_dup_checker_top_assert.svh"

module alloc_index_dup_checker_top #(
	parameter int MAX_BLOCKS = 4096,
	parameter int BLOCK_SIZE = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [aidc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aidc_pkg::ENTRY_W-1:0]       cfg_data,
	// entries
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [aidc_pkg::ENTRY_W-1:0] entry,
	input  logic                               block_end,
	input  logic                               scan_start,
	// results
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         entry_class,
	output logic                               is_duplicate,
	output logic [aidc_pkg::POS_O_W-1:0]       first_position,
	output logic [aidc_pkg::POS_O_W-1:0]       position,
	output logic                               new_duplicated_value,
	output logic [aidc_pkg::TOT_W-1:0]         total_allocated,
	output logic [aidc_pkg::TOT_W-1:0]         total_last,
	output logic [aidc_pkg::TOT_W-1:0]         total_free,
	output logic [aidc_pkg::TOT_W-1:0]         total_corrupt,
	output logic [aidc_pkg::TOT_W-1:0]         total_dup_values
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int PW = $clog2(BLOCK_SIZE);
	localparam logic [PW-1:0] POS_LAST = PW'(BLOCK_SIZE - 1);

	// configuration registers
	logic [aidc_pkg::BCNT_W-1:0]  block_count_q;
	logic [aidc_pkg::ENTRY_W-1:0] free_code_q;
	logic [aidc_pkg::ENTRY_W-1:0] last_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= aidc_pkg::BLOCK_COUNT_RST;
			free_code_q   <= aidc_pkg::FREE_CODE_RST;
			last_code_q   <= aidc_pkg::LAST_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aidc_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data[aidc_pkg::BCNT_W-1:0];
				aidc_pkg::CFG_FREE_CODE:   free_code_q   <= cfg_data;
				aidc_pkg::CFG_LAST_CODE:   last_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 0: classify and issue the table read
	logic                         accept;
	logic [aidc_pkg::ENTRY_W-1:0] e_u;
	logic                         is_alloc;
	aidc_pkg::cls_t               cls_s0;

	assign accept = in_valid && !in_stall;
	assign e_u    = $unsigned(entry);
	assign is_alloc = !e_u[aidc_pkg::ENTRY_W-1]
		&& (e_u < aidc_pkg::ENTRY_W'(block_count_q))
		&& (e_u < aidc_pkg::ENTRY_W'(MAX_BLOCKS));

	always_comb begin
		priority if (is_alloc)          cls_s0 = aidc_pkg::CLS_ALLOC;
		else if (e_u == last_code_q)    cls_s0 = aidc_pkg::CLS_LAST;
		else if (e_u == free_code_q)    cls_s0 = aidc_pkg::CLS_FREE;
		else                            cls_s0 = aidc_pkg::CLS_CORRUPT;
	end

	// stage 1 registers
	logic           valid_s1;
	aidc_pkg::cls_t cls_s1;
	logic [AW-1:0]  addr_s1;
	logic           bend_s1;
	logic           sstart_s1;

	logic [PW-1:0]  pos_q;
	logic [aidc_pkg::TOT_W-1:0] tot_q [aidc_pkg::TOT_N];

	aidc_pkg::tbl_ctl_t  tbl_ctl;
	aidc_pkg::tbl_wdat_t tbl_wdat;
	aidc_pkg::tbl_hit_t  tbl_hit;
	aidc_pkg::tbl_stat_t tbl_stat;

	logic                        adv;
	logic                        end_s1;
	logic                        alloc_s1;
	logic                        newdup_s1;
	logic [PW+aidc_pkg::POS_O_W-1:0] pos_ext;
	logic [aidc_pkg::POS_O_W-1:0] pos10_s1;
	logic [aidc_pkg::TOT_N-1:0]  inc_s1;
	logic [aidc_pkg::TOT_W-1:0]  tot_base [aidc_pkg::TOT_N];
	logic [aidc_pkg::TOT_W-1:0]  tot_nx [aidc_pkg::TOT_N];

	logic                         out_valid_q;
	aidc_pkg::cls_t               cls_q;
	logic                         is_dup_q;
	logic [aidc_pkg::POS_O_W-1:0] first_pos_q;
	logic [aidc_pkg::POS_O_W-1:0] pos_out_q;
	logic                         new_dup_q;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign end_s1    = bend_s1 || (pos_q == POS_LAST);
	assign alloc_s1  = (cls_s1 == aidc_pkg::CLS_ALLOC);
	assign newdup_s1 = alloc_s1 && tbl_hit.seen && !tbl_hit.dup;
	assign pos_ext   = {{aidc_pkg::POS_O_W{1'b0}}, pos_q};
	assign pos10_s1  = pos_ext[aidc_pkg::POS_O_W-1:0];

	// hold input while stage 1 is stuck, during a sweep, and while a
	// wrapping block end is about to start one
	assign in_stall = tbl_stat.clearing || (valid_s1 && !adv)
		|| (valid_s1 && end_s1 && tbl_stat.last_epoch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1    <= cls_s0;
			addr_s1   <= e_u[AW-1:0];
			bend_s1   <= block_end;
			sstart_s1 <= scan_start;
		end
	end

	assign tbl_ctl.rd_en   = accept;
	assign tbl_ctl.wr_en   = adv && alloc_s1;
	assign tbl_ctl.blk_adv = adv && end_s1;
	assign tbl_wdat.first_pos = tbl_hit.seen ? tbl_hit.first_pos : pos10_s1;
	assign tbl_wdat.dup       = tbl_hit.seen;

	aidc_seen_table #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (e_u[AW-1:0]),
		.wr_addr (addr_s1),
		.wr_dat  (tbl_wdat),
		.hit     (tbl_hit),
		.stat    (tbl_stat)
	);

	// running totals
	always_comb begin
		inc_s1                     = '0;
		inc_s1[aidc_pkg::TOT_ALLOC] = (cls_s1 == aidc_pkg::CLS_ALLOC);
		inc_s1[aidc_pkg::TOT_LAST]  = (cls_s1 == aidc_pkg::CLS_LAST);
		inc_s1[aidc_pkg::TOT_FREE]  = (cls_s1 == aidc_pkg::CLS_FREE);
		inc_s1[aidc_pkg::TOT_CORR]  = (cls_s1 == aidc_pkg::CLS_CORRUPT);
		inc_s1[aidc_pkg::TOT_DUPV]  = newdup_s1;
		for (int k = 0; k < aidc_pkg::TOT_N; k++) begin
			tot_base[k] = sstart_s1 ? '0 : tot_q[k];
			tot_nx[k]   = tot_base[k];
			if (inc_s1[k] && tot_base[k] != aidc_pkg::TOT_MAX) begin
				tot_nx[k] = tot_base[k] + aidc_pkg::TOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int k = 0; k < aidc_pkg::TOT_N; k++) begin
				tot_q[k] <= '0;
			end
		end else if (adv) begin
			pos_q <= end_s1 ? '0 : pos_q + PW'(1);
			for (int k = 0; k < aidc_pkg::TOT_N; k++) begin
				tot_q[k] <= tot_nx[k];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_q       <= cls_s1;
			is_dup_q    <= alloc_s1 && tbl_hit.seen;
			first_pos_q <= (alloc_s1 && tbl_hit.seen) ? tbl_hit.first_pos : '0;
			pos_out_q   <= pos10_s1;
			new_dup_q   <= newdup_s1;
		end
	end

	assign out_valid            = out_valid_q;
	assign entry_class          = cls_q;
	assign is_duplicate         = is_dup_q;
	assign first_position       = first_pos_q;
	assign position             = pos_out_q;
	assign new_duplicated_value = new_dup_q;
	assign total_allocated      = tot_q[aidc_pkg::TOT_ALLOC];
	assign total_last           = tot_q[aidc_pkg::TOT_LAST];
	assign total_free           = tot_q[aidc_pkg::TOT_FREE];
	assign total_corrupt        = tot_q[aidc_pkg::TOT_CORR];
	assign total_dup_values     = tot_q[aidc_pkg::TOT_DUPV];

	`AIDC_ASSERT_IMP(a_no_accept_in_clear, accept, !tbl_stat.clearing,
		"request accepted during table sweep")
	`AIDC_ASSERT_IMP(a_newdup_is_dup, out_valid_q && new_dup_q,
		is_dup_q && cls_q == aidc_pkg::CLS_ALLOC, "new duplicate without duplicate flag")
	`AIDC_ASSERT_NXT(a_pos_restart, adv && end_s1, pos_q == '0,
		"block position not restarted after block end")

endmodule

### tb/sv/aidc_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aidc_result_checker
// Watches the request and result channels of the allocation index duplicate
// checker, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module aidc_result_checker #(
	parameter int MAX_BLOCKS = 4096,
	parameter int BLOCK_SIZE = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aidc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aidc_pkg::ENTRY_W-1:0]        cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [aidc_pkg::ENTRY_W-1:0] entry,
	input  logic                                block_end,
	input  logic                                scan_start,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [1:0]                          entry_class,
	input  logic                                is_duplicate,
	input  logic [aidc_pkg::POS_O_W-1:0]        first_position,
	input  logic [aidc_pkg::POS_O_W-1:0]        position,
	input  logic                                new_duplicated_value,
	input  logic [aidc_pkg::TOT_W-1:0]          total_allocated,
	input  logic [aidc_pkg::TOT_W-1:0]          total_last,
	input  logic [aidc_pkg::TOT_W-1:0]          total_free,
	input  logic [aidc_pkg::TOT_W-1:0]          total_corrupt,
	input  logic [aidc_pkg::TOT_W-1:0]          total_dup_values,
	output int                                  fail_count
);
	import aidc_pkg::*;

	typedef struct packed {
		cls_t               cls;
		logic               dup;
		logic [POS_O_W-1:0] first_pos;
		logic [POS_O_W-1:0] pos;
		logic               new_dup;
		logic [TOT_W-1:0]   n_alloc;
		logic [TOT_W-1:0]   n_last;
		logic [TOT_W-1:0]   n_free;
		logic [TOT_W-1:0]   n_corrupt;
		logic [TOT_W-1:0]   n_dupv;
	} entry_result_t;

	// shadow registers
	logic [BCNT_W-1:0]  blk_count;
	logic [ENTRY_W-1:0] free_val;
	logic [ENTRY_W-1:0] last_val;

	// shadow of the per-block seen table
	bit                 seen_map [MAX_BLOCKS];
	bit                 dup_map  [MAX_BLOCKS];
	logic [POS_O_W-1:0] first_map [MAX_BLOCKS];
	int unsigned        blk_pos;
	logic [TOT_W-1:0]   tally [TOT_N];

	entry_result_t pending_results [$];
	entry_result_t oldest;
	entry_result_t fresh;
	int            mismatches;
	int            waiting;

	assign fail_count = mismatches + waiting;

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void count_up(int k);
		if (tally[k] != TOT_MAX)
			tally[k] = tally[k] + 1'b1;
	endfunction

	function automatic void clear_seen();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			seen_map[i] = 1'b0;
			dup_map[i]  = 1'b0;
		end
		blk_pos = 0;
	endfunction

	task automatic predict_entry(input logic [ENTRY_W-1:0] raw, input logic last_in_blk,
			input logic clr_totals, output entry_result_t res);
		int unsigned lim;
		int          idx;
		lim = (blk_count < MAX_BLOCKS) ? blk_count : MAX_BLOCKS;
		res = '0;
		res.pos = blk_pos[POS_O_W-1:0];
		if (clr_totals)
			for (int k = 0; k < TOT_N; k++)
				tally[k] = '0;
		// allocated range is tested first, then last, then free
		if (!raw[ENTRY_W-1] && raw < lim) begin
			idx = int'(raw);
			res.cls = CLS_ALLOC;
			count_up(TOT_ALLOC);
			if (seen_map[idx]) begin
				res.dup = 1'b1;
				res.first_pos = first_map[idx];
				if (!dup_map[idx]) begin
					dup_map[idx] = 1'b1;
					res.new_dup = 1'b1;
					count_up(TOT_DUPV);
				end
			end else begin
				seen_map[idx]  = 1'b1;
				first_map[idx] = blk_pos[POS_O_W-1:0];
			end
		end else if (raw == last_val) begin
			res.cls = CLS_LAST;
			count_up(TOT_LAST);
		end else if (raw == free_val) begin
			res.cls = CLS_FREE;
			count_up(TOT_FREE);
		end else begin
			res.cls = CLS_CORRUPT;
			count_up(TOT_CORR);
		end
		res.n_alloc   = tally[TOT_ALLOC];
		res.n_last    = tally[TOT_LAST];
		res.n_free    = tally[TOT_FREE];
		res.n_corrupt = tally[TOT_CORR];
		res.n_dupv    = tally[TOT_DUPV];
		if (last_in_blk || blk_pos + 1 >= BLOCK_SIZE)
			clear_seen();
		else
			blk_pos = blk_pos + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_count = BLOCK_COUNT_RST;
			free_val  = FREE_CODE_RST;
			last_val  = LAST_CODE_RST;
			for (int k = 0; k < TOT_N; k++)
				tally[k] = '0;
			clear_seen();
			pending_results.delete();
			mismatches = 0;
			waiting    = 0;
		end else begin
			// results first: a request taken at this edge cannot be answered at it
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no request pending");
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("entry_class", oldest.cls, entry_class);
					check_field("is_duplicate", oldest.dup, is_duplicate);
					check_field("first_position", oldest.first_pos, first_position);
					check_field("position", oldest.pos, position);
					check_field("new_duplicated_value", oldest.new_dup, new_duplicated_value);
					check_field("total_allocated", oldest.n_alloc, total_allocated);
					check_field("total_last", oldest.n_last, total_last);
					check_field("total_free", oldest.n_free, total_free);
					check_field("total_corrupt", oldest.n_corrupt, total_corrupt);
					check_field("total_dup_values", oldest.n_dupv, total_dup_values);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLOCK_COUNT: blk_count = cfg_data[BCNT_W-1:0];
					CFG_FREE_CODE:   free_val  = cfg_data;
					CFG_LAST_CODE:   last_val  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_entry(entry, block_end, scan_start, fresh);
				pending_results.push_back(fresh);
			end
			waiting = pending_results.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the allocation index duplicate checker: directed
// corner entries, then random blocks under several register settings, with
// random gaps on the request side and random stalls on the result side.
// ---------------------------------------------------------------------------
module tb;
	import aidc_pkg::*;

	localparam int MAX_BLOCKS     = 4096;
	localparam int BLOCK_SIZE     = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 30;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = CFG_BLOCK_COUNT;
	logic [ENTRY_W-1:0]        cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [ENTRY_W-1:0] entry = '0;
	logic                      block_end = 1'b0;
	logic                      scan_start = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                entry_class;
	logic                      is_duplicate;
	logic [POS_O_W-1:0]        first_position;
	logic [POS_O_W-1:0]        position;
	logic                      new_duplicated_value;
	logic [TOT_W-1:0]          total_allocated;
	logic [TOT_W-1:0]          total_last;
	logic [TOT_W-1:0]          total_free;
	logic [TOT_W-1:0]          total_corrupt;
	logic [TOT_W-1:0]          total_dup_values;
	int                        fail_count;

	// register values as last written, used to aim the random entries
	int unsigned        bc_now   = BLOCK_COUNT_RST;
	logic [ENTRY_W-1:0] free_now = FREE_CODE_RST;
	logic [ENTRY_W-1:0] last_now = LAST_CODE_RST;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int n_sent = 0;
	int n_recv = 0;
	int quiet_cycles = 0;

	alloc_index_dup_checker_top #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.BLOCK_SIZE(BLOCK_SIZE)
	) dut (.*);

	aidc_result_checker #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [ENTRY_W-1:0] pick_entry();
		int unsigned lim;
		int          r;
		lim = (bc_now < MAX_BLOCKS) ? bc_now : MAX_BLOCKS;
		r = $urandom_range(0, 99);
		if (lim > 0 && r < 45)
			return $urandom_range(0, (lim < 24) ? lim - 1 : 23);  // dense pool, many duplicates
		else if (lim > 0 && r < 60)
			return $urandom_range(0, lim - 1);
		else if (r < 70)
			return free_now;
		else if (r < 80)
			return last_now;
		else if (r < 85)
			return ($urandom_range(0, 1) == 0) ? ENTRY_W'(lim) : ENTRY_W'(lim) - 1'b1;
		return $urandom();
	endfunction

	// result side stall pattern
	initial begin
		int free_run;
		int hold;
		forever begin
			free_run = $urandom_range(1, 8);
			hold = rx_calm ? 0 : pick_gap();
			out_stall <= 1'b0;
			repeat (free_run) @(posedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// request/result bookkeeping and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				n_sent++;
			if (out_valid && !out_stall)
				n_recv++;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	task automatic send_entry(input logic [ENTRY_W-1:0] e, input logic last_in_blk,
			input logic clr_totals);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		entry      <= e;
		block_end  <= last_in_blk;
		scan_start <= clr_totals;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and wait until every request has its result back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (n_recv == n_sent);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic set_registers(input int unsigned bc, input logic [ENTRY_W-1:0] fc,
			input logic [ENTRY_W-1:0] lc);
		drain();
		write_reg(CFG_BLOCK_COUNT, ENTRY_W'(bc));
		write_reg(CFG_FREE_CODE, fc);
		write_reg(CFG_LAST_CODE, lc);
		@(posedge clk);
		cfg_we <= 1'b0;
		bc_now   = bc;
		free_now = fc;
		last_now = lc;
	endtask

	task automatic random_block(output int len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			len = $urandom_range(1, 3);
		else if (r < 85)
			len = $urandom_range(4, 16);
		else
			len = $urandom_range(17, 60);
		for (int i = 0; i < len; i++)
			send_entry(pick_entry(), i == len - 1, $urandom_range(0, 29) == 0);
	endtask

	initial begin
		int          left;
		int          blk_len;
		logic [31:0] shared;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: range ends, sentinels, sign extremes, repeats
		send_entry(32'd0, 1'b0, 1'b1);
		send_entry(32'd4095, 1'b0, 1'b0);
		send_entry(32'd0, 1'b0, 1'b0);
		send_entry(32'd0, 1'b0, 1'b0);
		send_entry(32'd4095, 1'b0, 1'b0);
		send_entry(32'd4096, 1'b0, 1'b0);
		send_entry(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_entry(32'hFFFF_FFFE, 1'b0, 1'b0);
		send_entry(32'h7FFF_FFFF, 1'b0, 1'b0);
		send_entry(32'h8000_0000, 1'b0, 1'b0);
		send_entry(32'd5, 1'b1, 1'b0);
		send_entry(32'd5, 1'b0, 1'b0);
		// totals clear, seen table kept
		send_entry(32'd5, 1'b0, 1'b1);
		send_entry(32'd1, 1'b1, 1'b0);

		// codes inside the allocated range: allocated wins
		set_registers(1, 32'd0, 32'd0);
		send_entry(32'd0, 1'b0, 1'b0);
		send_entry(32'd1, 1'b0, 1'b0);
		send_entry(32'd0, 1'b1, 1'b0);

		// no allocated range; equal codes make last win over free
		set_registers(0, 32'd5, 32'd5);
		send_entry(32'd0, 1'b0, 1'b0);
		send_entry(32'd5, 1'b1, 1'b0);

		// block count past the table size
		set_registers(8191, 32'h8000_0000, 32'h7FFF_FFFF);
		send_entry(32'd4095, 1'b0, 1'b0);
		send_entry(32'd4096, 1'b0, 1'b0);
		send_entry(32'd8190, 1'b0, 1'b0);
		send_entry(32'h8000_0000, 1'b0, 1'b0);
		send_entry(32'h7FFF_FFFF, 1'b1, 1'b0);

		for (int p = 0; p < N_PHASES; p++) begin
			shared = $urandom();
			case (p)
				0: set_registers(4096, FREE_CODE_RST, LAST_CODE_RST);
				1: set_registers(1, 32'h8000_0000, 32'h7FFF_FFFF);
				2: set_registers(8191, $urandom(), $urandom());
				3: set_registers(0, $urandom_range(0, 15), $urandom());
				4: set_registers($urandom_range(1, 4096), $urandom(), 32'hFFFF_0000 | $urandom());
				5: set_registers(4096, shared, shared);
				6: set_registers(16, 32'd3, 32'd20);
				default: set_registers($urandom_range(2, 64), FREE_CODE_RST, LAST_CODE_RST);
			endcase
			tx_calm = (p == 3);
			rx_calm = (p == 5);
			// enough one-entry blocks to wrap the block epoch at least once
			if (p == 2)
				for (int i = 0; i < 256; i++)
					send_entry(pick_entry(), 1'b1, $urandom_range(0, 29) == 0);
			// one block that runs past its size without a block end
			if (p == 6)
				for (int i = 0; i < BLOCK_SIZE + 6; i++)
					send_entry(pick_entry(), 1'b0, 1'b0);
			left = PHASE_ITEMS;
			while (left > 0) begin
				random_block(blk_len);
				left = left - blk_len;
			end
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### alloc_index_dup_checker_top.f
+incdir+rtl
rtl/aidc_pkg.sv
rtl/aidc_seen_table.sv
rtl/alloc_index_dup_checker_top.sv
tb/sv/aidc_result_checker.sv
tb/sv/tb.sv
